// ===== sv/rtbl_pkg.sv =====
// Shared types and constants for the IPv4 route table.
// Used by rtbl_ctrl, rtbl_dpath and ipv4_route_table; no dependencies.
package rtbl_pkg;

    localparam int MAX_ROUTES_DEF = 8;

    localparam logic [31:0] BCAST_ADDR    = 32'hffff_ffff;
    localparam logic [31:0] LOOPBACK_ADDR = 32'h7f00_0001;

    // stream word layout
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 72;
    localparam int M_PAD_W   = M_TDATA_W - 67;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_LOCAL  = 2'd2
    } req_e_t;

    typedef enum logic [1:0] {
        RES_OK       = 2'd0,
        RES_NO_ROUTE = 2'd1,
        RES_FULL     = 2'd2
    } res_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_INS_RD,
        ST_INS_CMP,
        ST_INS_PLACE,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic [1:0]  iface;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic ins_read;
        logic ins_shift;
        logic ins_place;
        logic set_full;
        logic out_load;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] req;
        logic       full;
        logic       ins_at_zero;
        logic       ins_at_one;
        logic       ge;
        logic       hit;
        logic       exhausted;
        logic       out_free;
    } dp_stat_t;

endpackage

// ===== sv/ipv4_route_table.sv =====
// IPv4 route table top level: stream ports, controller and datapath.
// Depends on rtbl_pkg, rtbl_ctrl, rtbl_dpath (and rtbl_ram below it).
//
// Fixed-size IPv4 route table kept sorted by decreasing mask, one request
// word in, one result word out. s_tuser selects insert, lookup or local check;
// a lookup returns the first entry whose masked address matches. Entries live
// in a RAM with registered read, so a lookup or local check reads one entry
// per cycle. An insert moves each entry below the new slot down with a read
// then a write. One request is in flight at a time; the result register lets
// a new request be taken while the previous result still waits. The table is
// empty after reset; no clearing pass.
module ipv4_route_table #(
    parameter int MAX_ROUTES = rtbl_pkg::MAX_ROUTES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // addr[31:0], mask[63:32], gateway[95:64], iface[97:96], zero pad
    input  logic [rtbl_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type[1:0]
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_iface[1:0], next_hop[33:2], is_local[34], primary_addr[66:35], zero pad
    output logic [rtbl_pkg::M_TDATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [1:0]                     m_tuser
);
    import rtbl_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    rtbl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rtbl_dpath #(
        .MAX_ROUTES (MAX_ROUTES)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

// ===== sv/rtbl_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module rtbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/rtbl_ctrl.sv =====
// Request sequencer for the route table: scan, shift-insert and response steps.
// Depends on rtbl_pkg; drives rtbl_dpath through ctrl_cmd_t.
module rtbl_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  rtbl_pkg::dp_stat_t  stat,
    output rtbl_pkg::ctrl_cmd_t cmd
);
    import rtbl_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (stat.req)
                    REQ_INSERT: begin
                        if (stat.full) begin
                            cmd.set_full = 1'b1;
                            state_next   = ST_RESP;
                        end else if (stat.ins_at_zero) begin
                            state_next = ST_INS_PLACE;
                        end else begin
                            state_next = ST_INS_RD;
                        end
                    end
                    REQ_LOOKUP, REQ_LOCAL: state_next = ST_SCAN;
                    default:               state_next = ST_RESP;
                endcase
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.hit || stat.exhausted) begin
                    state_next = ST_RESP;
                end
            end
            ST_INS_RD: begin
                cmd.ins_read = 1'b1;
                state_next   = ST_INS_CMP;
            end
            ST_INS_CMP: begin
                // entry above the slot has mask <= new mask: move it down one
                if (stat.ge) begin
                    cmd.ins_shift = 1'b1;
                    state_next    = stat.ins_at_one ? ST_INS_PLACE : ST_INS_RD;
                end else begin
                    cmd.ins_place = 1'b1;
                    state_next    = ST_RESP;
                end
            end
            ST_INS_PLACE: begin
                cmd.ins_place = 1'b1;
                state_next    = ST_RESP;
            end
            ST_RESP: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.ins_shift || cmd.ins_place) |-> $past(cmd.ins_read) || state_reg == ST_INS_PLACE)
        else $error("insert write without preceding read");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == ST_DISPATCH)
        else $error("accepted word not dispatched");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && stat.hit) |=> state_reg == ST_RESP)
        else $error("scan hit did not end the scan");

endmodule

// ===== sv/rtbl_dpath.sv =====
// Route table datapath: request registers, entry RAM, scan and insert indexes,
// result and output registers. Depends on rtbl_pkg and rtbl_ram.
module rtbl_dpath #(
    parameter int MAX_ROUTES = rtbl_pkg::MAX_ROUTES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [rtbl_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rtbl_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [1:0]                     m_tuser,
    input  rtbl_pkg::ctrl_cmd_t            cmd,
    output rtbl_pkg::dp_stat_t             stat
);
    import rtbl_pkg::*;

    localparam int IDX_W = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
    localparam int CNT_W = $clog2(MAX_ROUTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ROUTES);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    req_e_t                 req_reg;
    logic [31:0]            addr_reg, mask_reg, gw_reg;
    logic [1:0]             iface_reg;
    logic [CNT_W-1:0]       count_reg, issue_reg, ins_reg;
    logic                   vld_reg;
    logic [31:0]            primary_reg;
    res_status_t            res_status_reg;
    logic [1:0]             res_iface_reg;
    logic [31:0]            res_hop_reg;
    logic                   res_local_reg;
    logic                   m_valid_reg;
    logic [M_TDATA_W-1:0]   m_data_reg;
    logic [1:0]             m_user_reg;

    entry_t                 rd_entry, wr_entry, new_entry;
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr, ram_raddr;
    logic [CNT_W-1:0]       ins_m1;
    logic                   issue_ok, match;
    logic [31:0]            hop;

    assign new_entry = '{addr: addr_reg, mask: mask_reg, gateway: gw_reg, iface: iface_reg};
    assign ins_m1    = ins_reg - CNT_ONE;
    assign issue_ok  = cmd.scan && (issue_reg != count_reg);
    assign ram_we    = cmd.ins_shift || cmd.ins_place;
    assign ram_waddr = ins_reg[IDX_W-1:0];
    assign wr_entry  = cmd.ins_shift ? rd_entry : new_entry;
    assign ram_raddr = cmd.scan ? issue_reg[IDX_W-1:0] : ins_m1[IDX_W-1:0];

    rtbl_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_ROUTES),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_entry),
        .raddr (ram_raddr),
        .rdata (rd_entry)
    );

    always_comb begin
        if (req_reg == REQ_LOOKUP) begin
            match = (addr_reg & rd_entry.mask) == (rd_entry.addr & rd_entry.mask);
        end else begin
            match = (addr_reg == rd_entry.addr);
        end
        hop = (rd_entry.gateway == 32'd0 || addr_reg == BCAST_ADDR) ? addr_reg
                                                                   : rd_entry.gateway;
    end

    assign stat.req         = req_reg;
    assign stat.full        = (count_reg == CNT_MAX);
    assign stat.ins_at_zero = (ins_reg == '0);
    assign stat.ins_at_one  = (ins_reg == CNT_ONE);
    assign stat.ge          = (mask_reg >= rd_entry.mask);
    assign stat.hit         = vld_reg && match;
    assign stat.exhausted   = (issue_reg == count_reg) && !vld_reg;
    assign stat.out_free    = !m_valid_reg || m_tready;

    // request, result, primary-address and output registers (payload)
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg        <= req_e_t'(s_tuser);
            addr_reg       <= s_tdata[31:0];
            mask_reg       <= s_tdata[63:32];
            gw_reg         <= s_tdata[95:64];
            iface_reg      <= s_tdata[97:96];
            res_status_reg <= (req_e_t'(s_tuser) == REQ_LOOKUP) ? RES_NO_ROUTE : RES_OK;
            res_iface_reg  <= 2'd0;
            res_hop_reg    <= 32'd0;
            res_local_reg  <= 1'b0;
        end else begin
            if (cmd.set_full) begin
                res_status_reg <= RES_FULL;
            end
            if (cmd.scan && stat.hit) begin
                if (req_reg == REQ_LOOKUP) begin
                    res_status_reg <= RES_OK;
                    res_iface_reg  <= rd_entry.iface;
                    res_hop_reg    <= hop;
                end else begin
                    res_local_reg <= 1'b1;
                end
            end
        end
        if (ram_we && ram_waddr == '0) begin
            primary_reg <= wr_entry.addr;
        end
        if (cmd.out_load) begin
            m_user_reg <= res_status_reg;
            m_data_reg <= {{M_PAD_W{1'b0}},
                           (count_reg != '0) ? primary_reg : LOOPBACK_ADDR,
                           res_local_reg, res_hop_reg, res_iface_reg};
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            issue_reg   <= '0;
            ins_reg     <= '0;
            vld_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                issue_reg <= '0;
                ins_reg   <= count_reg;
                vld_reg   <= 1'b0;
            end else begin
                vld_reg <= issue_ok;
                if (issue_ok) begin
                    issue_reg <= issue_reg + CNT_ONE;
                end
                if (cmd.ins_shift) begin
                    ins_reg <= ins_m1;
                end
            end
            if (cmd.ins_place) begin
                count_reg <= count_reg + CNT_ONE;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_MAX)
        else $error("entry count beyond table size");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins_place |=> count_reg == $past(count_reg) + CNT_ONE)
        else $error("insert did not bump entry count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_tready))
        else $error("result overwrote a word not yet taken");

endmodule
